// ----- sv/ira_pkg.sv -----
// ----------------------------------------------------------------------------
// ira_pkg
// shared types and constants of the interval resource allotter
// ----------------------------------------------------------------------------
package ira_pkg;

  localparam int unsigned ID_W   = 8;
  localparam int unsigned TIME_W = 12;
  localparam int unsigned OUT_W  = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_DN_LEFT,
    ST_DN_RIGHT,
    ST_DN_CMP,
    ST_UP_READ,
    ST_UP_CMP,
    ST_DONE
  } state_e;

endpackage

// ----- sv/ira_heap_ram.sv -----
// ----------------------------------------------------------------------------
// ira_heap_ram
// heap store, one write port and one registered read port
// ----------------------------------------------------------------------------
module ira_heap_ram #(
  parameter int unsigned DEPTH  = 128,
  parameter int unsigned DATA_W = 20
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/interval_resource_allotter_unit.sv -----
// ----------------------------------------------------------------------------
// interval_resource_allotter_unit
// allots resources to occupancy intervals through a min-heap of release times
// ----------------------------------------------------------------------------
//  channel | handshake                 | transaction payload
//  --------+---------------------------+-----------------------------------------
//  in      | in_valid_i, in_stall_o    | item id, start time, end time, last flag
//  out     | out_valid_o, out_stall_i  | item id, resource, reused, count, overflow, done
//
// one transaction at a time: root read and decision, then per level down a left read,
// right read and compare, or per level up a parent read and compare, then the leaf write
// and the result load
// in_stall_o is high from acceptance until the result is loaded into the output register;
// a stalled result holds there while the next item is taken
// reset clears the count, the sequencer and the output valid only; ram entries above the count are never read
// ----------------------------------------------------------------------------
module interval_resource_allotter_unit #(
  parameter int unsigned MAX_RESOURCES = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input transaction
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ira_pkg::ID_W-1:0]   item_id_i,
  input  logic [ira_pkg::TIME_W-1:0] start_time_i,
  input  logic [ira_pkg::TIME_W-1:0] end_time_i,
  input  logic                       last_item_i,
  // output transaction
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ira_pkg::ID_W-1:0]   out_item_id_o,
  output logic [ira_pkg::OUT_W-1:0]  resource_number_o,
  output logic                       was_reused_o,
  output logic [ira_pkg::OUT_W-1:0]  resources_used_o,
  output logic                       overflow_o,
  output logic                       batch_done_o
);

  // count and resource numbers reach MAX_RESOURCES itself
  localparam int unsigned CNT_W   = $clog2(MAX_RESOURCES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RESOURCES);
  localparam int unsigned CHILD_W = CNT_W + 1;
  localparam int unsigned TIME_W  = ira_pkg::TIME_W;
  // an entry is {release time, resource}: plain unsigned compare gives
  // the time-then-resource order
  localparam int unsigned ENT_W   = TIME_W + CNT_W;

  ira_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]           count_q, count_d;
  logic [ira_pkg::ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0]          start_q, start_d;
  logic [TIME_W-1:0]          end_q, end_d;
  logic                       last_q, last_d;
  logic [ENT_W-1:0]           x_q, x_d;        // element being placed
  logic [IDX_W-1:0]           pos_q, pos_d;    // hole position
  logic [ENT_W-1:0]           best_q, best_d;  // left child
  logic [IDX_W-1:0]           best_idx_q, best_idx_d;
  logic                       have_r_q, have_r_d;
  logic [CNT_W-1:0]           res_q, res_d;
  logic                       reused_q, reused_d;
  logic                       ovf_q, ovf_d;

  logic                       out_valid_q, out_valid_d;
  logic [ira_pkg::ID_W-1:0]   out_id_q, out_id_d;
  logic [ira_pkg::OUT_W-1:0]  out_res_q, out_res_d;
  logic                       out_reused_q, out_reused_d;
  logic [ira_pkg::OUT_W-1:0]  out_used_q, out_used_d;
  logic                       out_ovf_q, out_ovf_d;
  logic                       out_done_q, out_done_d;

  // heap ram ports
  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [ENT_W-1:0]           rd_data;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [ENT_W-1:0]           wr_data;

  // child and parent indexes of the hole
  logic [CHILD_W-1:0]         left_idx;
  logic [CHILD_W-1:0]         right_idx;
  logic [IDX_W-1:0]           parent_idx;
  logic [IDX_W-1:0]           pos_m1;
  logic                       take_right;
  logic [ENT_W-1:0]           child_ent;
  logic [IDX_W-1:0]           child_idx;
  logic                       in_acc;
  logic                       out_free;

  assign left_idx   = CHILD_W'({pos_q, 1'b1});
  assign right_idx  = left_idx + CHILD_W'(1);
  assign pos_m1     = pos_q - IDX_W'(1);
  assign parent_idx = pos_m1 >> 1;
  assign take_right = have_r_q && (rd_data < best_q);
  assign child_ent  = take_right ? rd_data : best_q;
  assign child_idx  = take_right ? (best_idx_q + IDX_W'(1)) : best_idx_q;

  assign in_stall_o = (state_q != ira_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  ira_heap_ram #(
    .DEPTH  (MAX_RESOURCES),
    .DATA_W (ENT_W)
  ) u_heap (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    id_d         = id_q;
    start_d      = start_q;
    end_d        = end_q;
    last_d       = last_q;
    x_d          = x_q;
    pos_d        = pos_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    have_r_d     = have_r_q;
    res_d        = res_q;
    reused_d     = reused_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_id_d     = out_id_q;
    out_res_d    = out_res_q;
    out_reused_d = out_reused_q;
    out_used_d   = out_used_q;
    out_ovf_d    = out_ovf_q;
    out_done_d   = out_done_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = pos_q;
    wr_data      = x_q;

    unique case (state_q)
      ira_pkg::ST_IDLE: begin
        if (in_acc) begin
          id_d    = item_id_i;
          start_d = start_time_i;
          end_d   = end_time_i;
          last_d  = last_item_i;
          rd_en   = 1'b1;   // fetch the root
          rd_addr = '0;
          state_d = ira_pkg::ST_DECIDE;
        end
      end
      ira_pkg::ST_DECIDE: begin
        reused_d = 1'b0;
        ovf_d    = 1'b0;
        if ((count_q != '0) && (start_q >= rd_data[ENT_W-1 -: TIME_W])) begin
          // reuse the earliest released resource, sift the new time down
          res_d    = rd_data[CNT_W-1:0];
          reused_d = 1'b1;
          x_d      = {end_q, rd_data[CNT_W-1:0]};
          pos_d    = '0;
          state_d  = ira_pkg::ST_DN_LEFT;
        end else if (count_q < CNT_W'(MAX_RESOURCES)) begin
          // new resource, push at the end and sift up
          res_d   = count_q + CNT_W'(1);
          x_d     = {end_q, count_q + CNT_W'(1)};
          pos_d   = count_q[IDX_W-1:0];
          count_d = count_q + CNT_W'(1);
          state_d = ira_pkg::ST_UP_READ;
        end else begin
          // capacity exhausted, store untouched
          res_d   = '0;
          ovf_d   = 1'b1;
          state_d = ira_pkg::ST_DONE;
        end
      end
      ira_pkg::ST_DN_LEFT: begin
        if (left_idx < CHILD_W'(count_q)) begin
          rd_en   = 1'b1;
          rd_addr = left_idx[IDX_W-1:0];
          state_d = ira_pkg::ST_DN_RIGHT;
        end else begin
          wr_en   = 1'b1;
          state_d = ira_pkg::ST_DONE;
        end
      end
      ira_pkg::ST_DN_RIGHT: begin
        best_d     = rd_data;
        best_idx_d = left_idx[IDX_W-1:0];
        have_r_d   = right_idx < CHILD_W'(count_q);
        rd_en      = right_idx < CHILD_W'(count_q);
        rd_addr    = right_idx[IDX_W-1:0];
        state_d    = ira_pkg::ST_DN_CMP;
      end
      ira_pkg::ST_DN_CMP: begin
        wr_en = 1'b1;
        if (child_ent < x_q) begin
          // smaller child moves up into the hole
          wr_data = child_ent;
          pos_d   = child_idx;
          state_d = ira_pkg::ST_DN_LEFT;
        end else begin
          state_d = ira_pkg::ST_DONE;
        end
      end
      ira_pkg::ST_UP_READ: begin
        if (pos_q == '0) begin
          wr_en   = 1'b1;
          state_d = ira_pkg::ST_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_idx;
          state_d = ira_pkg::ST_UP_CMP;
        end
      end
      ira_pkg::ST_UP_CMP: begin
        wr_en = 1'b1;
        if (x_q < rd_data) begin
          // parent moves down into the hole
          wr_data = rd_data;
          pos_d   = parent_idx;
          state_d = ira_pkg::ST_UP_READ;
        end else begin
          state_d = ira_pkg::ST_DONE;
        end
      end
      ira_pkg::ST_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_id_d     = id_q;
          out_res_d    = ira_pkg::OUT_W'(res_q);
          out_reused_d = reused_q;
          out_used_d   = ira_pkg::OUT_W'(count_q);
          out_ovf_d    = ovf_q;
          out_done_d   = last_q;
          if (last_q) begin
            count_d = '0;   // end of batch
          end
          state_d = ira_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ira_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ira_pkg::ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    start_q      <= start_d;
    end_q        <= end_d;
    last_q       <= last_d;
    x_q          <= x_d;
    pos_q        <= pos_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    have_r_q     <= have_r_d;
    res_q        <= res_d;
    reused_q     <= reused_d;
    ovf_q        <= ovf_d;
    out_id_q     <= out_id_d;
    out_res_q    <= out_res_d;
    out_reused_q <= out_reused_d;
    out_used_q   <= out_used_d;
    out_ovf_q    <= out_ovf_d;
    out_done_q   <= out_done_d;
  end

  assign out_valid_o       = out_valid_q;
  assign out_item_id_o     = out_id_q;
  assign resource_number_o = out_res_q;
  assign was_reused_o      = out_reused_q;
  assign resources_used_o  = out_used_q;
  assign overflow_o        = out_ovf_q;
  assign batch_done_o      = out_done_q;

endmodule

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for interval_resource_allotter_unit: a queue-fed driver
// offers intervals, a predicting heap model computes each expected allotment,
// and a monitor compares every result transaction field by field
// ----------------------------------------------------------------------------
module tb;

  localparam int MAX_RES  = 128;
  localparam int LIMIT    = 600000;  // cycles before the run is declared hung
  localparam int HOLD_AT  = 3000;    // cycle at which the long receiver hold starts
  localparam int HOLD_LEN = 500;     // length of that hold in cycles
  localparam int CALM_TAIL = 150;    // last transactions run without idling

  typedef struct {
    logic [ira_pkg::ID_W-1:0]   id;
    logic [ira_pkg::TIME_W-1:0] t_start;
    logic [ira_pkg::TIME_W-1:0] t_end;
    logic                       last;
  } interval_t;

  typedef struct {
    logic [ira_pkg::ID_W-1:0]  id;
    logic [ira_pkg::OUT_W-1:0] res;
    logic                      reused;
    logic [ira_pkg::OUT_W-1:0] used;
    logic                      ovf;
    logic                      done;
  } allot_t;

  // clock, reset and block ports; the inputs are known from time zero
  logic                       clk_i        = 1'b0;
  logic                       rst_ni       = 1'b0;
  logic                       in_valid_i   = 1'b0;
  logic                       in_stall_o;
  logic [ira_pkg::ID_W-1:0]   item_id_i    = '0;
  logic [ira_pkg::TIME_W-1:0] start_time_i = '0;
  logic [ira_pkg::TIME_W-1:0] end_time_i   = '0;
  logic                       last_item_i  = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i  = 1'b0;
  logic [ira_pkg::ID_W-1:0]   out_item_id_o;
  logic [ira_pkg::OUT_W-1:0]  resource_number_o;
  logic                       was_reused_o;
  logic [ira_pkg::OUT_W-1:0]  resources_used_o;
  logic                       overflow_o;
  logic                       batch_done_o;

  // stimulus and scoreboard
  interval_t interval_q[$];
  allot_t    allot_q[$];
  int        total_items = 0;
  int        sent_cnt    = 0;
  int        got_cnt     = 0;
  int        err_cnt     = 0;
  logic      hold_on     = 1'b0;

  // predictor state: release heap ordered by (time, resource)
  logic [ira_pkg::TIME_W-1:0] rel_time[MAX_RES];
  int                         rel_res[MAX_RES];
  int                         heap_cnt = 0;
  int                         next_res = 1;

  interval_resource_allotter_unit #(
    .MAX_RESOURCES(MAX_RES)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .item_id_i        (item_id_i),
    .start_time_i     (start_time_i),
    .end_time_i       (end_time_i),
    .last_item_i      (last_item_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_item_id_o    (out_item_id_o),
    .resource_number_o(resource_number_o),
    .was_reused_o     (was_reused_o),
    .resources_used_o (resources_used_o),
    .overflow_o       (overflow_o),
    .batch_done_o     (batch_done_o)
  );

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic bit entry_less(int a, int b);
    if (rel_time[a] != rel_time[b]) return rel_time[a] < rel_time[b];
    return rel_res[a] < rel_res[b];
  endfunction

  function automatic void swap_entries(int a, int b);
    logic [ira_pkg::TIME_W-1:0] t;
    int r;
    t = rel_time[a];
    r = rel_res[a];
    rel_time[a] = rel_time[b];
    rel_res[a]  = rel_res[b];
    rel_time[b] = t;
    rel_res[b]  = r;
  endfunction

  // allot a resource to one interval and update the heap
  function automatic allot_t allot_interval(interval_t it);
    allot_t r;
    int pos;
    int best;
    int kid;
    bit moving;
    r.id     = it.id;
    r.res    = '0;
    r.reused = 1'b0;
    r.ovf    = 1'b0;
    r.done   = it.last;
    if (heap_cnt > 0 && it.t_start >= rel_time[0]) begin
      // earliest release already passed: replace the root and sift it down
      r.res       = rel_res[0][ira_pkg::OUT_W-1:0];
      r.reused    = 1'b1;
      rel_time[0] = it.t_end;
      pos    = 0;
      moving = 1'b1;
      while (moving) begin
        best = pos;
        kid  = 2 * pos + 1;
        if (kid < heap_cnt && entry_less(kid, best)) best = kid;
        if (kid + 1 < heap_cnt && entry_less(kid + 1, best)) best = kid + 1;
        if (best == pos) begin
          moving = 1'b0;
        end else begin
          swap_entries(pos, best);
          pos = best;
        end
      end
    end else if (heap_cnt < MAX_RES && next_res - 1 < MAX_RES) begin
      // open a new resource and sift it up
      r.res              = next_res[ira_pkg::OUT_W-1:0];
      rel_time[heap_cnt] = it.t_end;
      rel_res[heap_cnt]  = next_res;
      next_res++;
      heap_cnt++;
      pos = heap_cnt - 1;
      while (pos > 0 && entry_less(pos, (pos - 1) / 2)) begin
        swap_entries(pos, (pos - 1) / 2);
        pos = (pos - 1) / 2;
      end
    end else begin
      r.ovf = 1'b1;  // capacity exhausted, state saturates
    end
    r.used = ira_pkg::OUT_W'(next_res - 1);
    if (it.last) begin
      heap_cnt = 0;
      next_res = 1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  task automatic add_interval(int id, int s, int e, bit last);
    interval_t it;
    it.id      = id[ira_pkg::ID_W-1:0];
    it.t_start = s[ira_pkg::TIME_W-1:0];
    it.t_end   = e[ira_pkg::TIME_W-1:0];
    it.last    = last;
    interval_q.push_back(it);
  endtask

  // enough overlapping intervals to use up every resource and then overflow
  task automatic add_fill_batch();
    int n;
    int s;
    n = MAX_RES + $urandom_range(1, 5);
    s = $urandom_range(0, 20);
    for (int k = 0; k < n; k++) begin
      s += $urandom_range(0, 1);
      add_interval($urandom_range(0, 255), s, $urandom_range(2000, 2359), 1'b0);
    end
    // late arrivals still reuse while the batch is saturated
    add_interval($urandom_range(0, 255), 2359, 2359, 1'b0);
    add_interval($urandom_range(0, 255), 2359, $urandom_range(0, 4095), 1'b0);
    add_interval($urandom_range(0, 255), 0, $urandom_range(0, 4095), 1'b1);
  endtask

  // sorted batch; when broken is set some items get disordered or wild times
  task automatic add_sorted_batch(bit broken);
    int n;
    int q;
    int t;
    int e;
    int spread;
    n      = $urandom_range(1, 40);
    q      = $urandom_range(0, 1) ? 30 : 1;  // coarse times force equal releases
    t      = $urandom_range(0, 20) * q;
    spread = $urandom_range(1, 600);
    for (int k = 0; k < n; k++) begin
      t += $urandom_range(0, 45 / q) * q;
      if (t > 2359) t = 2359;
      e = t + $urandom_range(1, 1 + spread / q) * q;
      if (e > 2359) e = 2359;
      if (broken) begin
        case ($urandom_range(0, 5))
          0: add_interval($urandom_range(0, 255), e, t, k == n - 1);
          1: add_interval($urandom_range(0, 255), $urandom_range(0, 4095), e,
                          k == n - 1);
          2: add_interval($urandom_range(0, 255), t, t, k == n - 1);
          3: add_interval($urandom_range(0, 255), t, $urandom_range(0, 4095),
                          k == n - 1);
          default: add_interval($urandom_range(0, 255), t, e, k == n - 1);
        endcase
      end else begin
        add_interval($urandom_range(0, 255), t, e, k == n - 1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // clock, reset, run control
  // ---------------------------------------------------------------------------

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    int pick;
    // directed: extremes, reuse at equal time, ties, disorder, wild times
    add_interval(0, 0, 2359, 1'b0);       // first resource
    add_interval(255, 0, 100, 1'b0);      // second resource
    add_interval(1, 100, 200, 1'b0);      // reuse at exactly the release time
    add_interval(2, 99, 300, 1'b0);       // arrival earlier than previous one
    add_interval(3, 4095, 0, 1'b0);       // end before start, max time
    add_interval(4, 0, 4095, 1'b1);       // end of batch
    add_interval(5, 900, 1000, 1'b0);
    add_interval(6, 900, 1000, 1'b0);
    add_interval(7, 1000, 1100, 1'b0);    // tie on release: lower resource wins
    add_interval(8, 1000, 1100, 1'b0);
    add_interval(9, 930, 940, 1'b0);      // arrival out of order
    add_interval(10, 1200, 1200, 1'b0);   // empty interval
    add_interval(11, 1200, 1100, 1'b0);
    add_interval(12, 2359, 2359, 1'b1);
    add_interval(170, 2730, 1365, 1'b1);  // single-item batch, alternating bits
    add_interval(85, 1365, 2730, 1'b1);
    add_interval(128, 0, 0, 1'b0);
    add_interval(127, 0, 0, 1'b0);        // end 0 releases at once
    add_interval(64, 1, 2, 1'b1);
    add_fill_batch();
    // random batches, mostly well-formed
    while (interval_q.size() < 1875) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) begin
        add_sorted_batch(1'b0);
      end else if (pick < 84) begin
        add_sorted_batch(1'b1);
      end else if (pick < 98) begin
        repeat ($urandom_range(1, 20))
          add_interval($urandom_range(0, 255), $urandom_range(0, 4095),
                       $urandom_range(0, 4095), $urandom_range(0, 5) == 0);
      end else begin
        add_fill_batch();
      end
    end
    add_interval($urandom_range(0, 255), 0, 1, 1'b1);
    total_items = interval_q.size();

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (sent_cnt < total_items || allot_q.size() > 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[interval_resource_allotter_unit] OK");
    end else begin
      $display("[interval_resource_allotter_unit] ERROR");
    end
    $finish;
  end

  // watchdog
  always @(posedge clk_i) begin
    int cyc;
    cyc++;
    if (cyc == LIMIT) begin
      $display("%0t hung: %0d of %0d sent, %0d results pending", $time, sent_cnt,
               total_items, allot_q.size());
      $display("[interval_resource_allotter_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: one offered transaction at a time, held while stalled
  // ---------------------------------------------------------------------------

  interval_t cur_item;
  int        in_gap = 0;

  always @(posedge clk_i) begin
    bit quiet;
    if (rst_ni) begin
      quiet = ((sent_cnt / 128) % 4 == 3) || (interval_q.size() < CALM_TAIL);
      if (in_valid_i && !in_stall_o) begin
        allot_q.push_back(allot_interval(cur_item));
        sent_cnt++;
        if (!quiet && $urandom_range(0, 5) == 0) in_gap = $urandom_range(1, 18);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (interval_q.size() > 0) begin
          cur_item     = interval_q.pop_front();
          in_valid_i   <= 1'b1;
          item_id_i    <= cur_item.id;
          start_time_i <= cur_item.t_start;
          end_time_i   <= cur_item.t_end;
          last_item_i  <= cur_item.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold so the block backs up and stalls its input
  always @(posedge clk_i) begin
    int hold_clk;
    if (rst_ni) begin
      hold_clk++;
      hold_on <= (hold_clk >= HOLD_AT) && (hold_clk < HOLD_AT + HOLD_LEN);
    end
  end

  // ---------------------------------------------------------------------------
  // monitor and receiver stall
  // ---------------------------------------------------------------------------

  task automatic check_field(string what, logic [11:0] exp_v, logic [11:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, what, exp_v, act_v);
      err_cnt++;
    end
  endtask

  int rx_burst = 0;

  always @(posedge clk_i) begin
    allot_t want;
    bit quiet;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (allot_q.size() == 0) begin
          $display("%0t result with nothing expected: expected none actual id %0d",
                   $time, out_item_id_o);
          err_cnt++;
        end else begin
          want = allot_q.pop_front();
          check_field("item_id", 12'(want.id), 12'(out_item_id_o));
          check_field("resource_number", 12'(want.res), 12'(resource_number_o));
          check_field("was_reused", 12'(want.reused), 12'(was_reused_o));
          check_field("resources_used", 12'(want.used), 12'(resources_used_o));
          check_field("overflow", 12'(want.ovf), 12'(overflow_o));
          check_field("batch_done", 12'(want.done), 12'(batch_done_o));
        end
        got_cnt++;
      end
      quiet = ((got_cnt / 128) % 4 == 1) || (got_cnt + CALM_TAIL >= total_items);
      if (rx_burst > 0) begin
        rx_burst--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_burst = $urandom_range(1, 18);
      end
      out_stall_i <= hold_on || (rx_burst > 0);
    end
  end

endmodule
